[hdl/tlc_pkg.sv]
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the TTL/LRU lookup cache
// Item formats, status and opcode codes, the scan token that runs along the
// row of cells and the write-back command broadcast to them.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  // Slot indices travel at the width of the largest supported cache.
  localparam int unsigned IDX_W           = 10;

  localparam logic [31:0] MAX_TTL_RESET = 32'd86400;
  localparam logic [31:0] ALL_ONES32    = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_EXPIRED  = 3'd2;
  localparam logic [2:0] ST_UPDATED  = 3'd3;
  localparam logic [2:0] ST_FILLED   = 3'd4;
  localparam logic [2:0] ST_EVICTED  = 3'd5;
  localparam logic [2:0] ST_REJECTED = 3'd6;
  localparam logic [2:0] ST_CLEARED  = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] name_key;
    logic [31:0] address_in;
    logic [31:0] ttl_in;
    logic [31:0] now_seconds;
  } tlc_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] address_out;
    logic [2:0]  status;
  } tlc_rsp_t;

  typedef struct packed {
    logic             active;
    logic [63:0]      name_key;
    logic             match;
    logic [IDX_W-1:0] match_idx;
    logic [31:0]      match_addr;
    logic [32:0]      match_exp;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      oldest;
    logic [IDX_W-1:0] oldest_idx;
  } tlc_token_t;

  typedef enum logic [1:0] {
    WR_FULL,
    WR_TOUCH,
    WR_KILL,
    WR_CLEAR
  } tlc_wr_e;

  typedef struct packed {
    logic             en;
    tlc_wr_e          kind;
    logic [IDX_W-1:0] idx;
    logic [63:0]      name_key;
    logic [31:0]      address;
    logic [32:0]      expiry;
    logic [31:0]      now;
  } tlc_wcmd_t;

endpackage

[hdl/tlc_cell.sv]
// ----------------------------------------------------------------------------
// tlc_cell: one cache slot
// Holds one entry, folds it into the passing scan token and applies the
// write-back commands addressed to it or broadcast as a clear.
// ----------------------------------------------------------------------------
module tlc_cell
  import tlc_pkg::*;
#(
  parameter int unsigned SLOT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  tlc_token_t tok_in,
  input  tlc_wcmd_t  wcmd,
  output tlc_token_t tok_out
);

  localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(SLOT);

  logic        valid;
  logic [63:0] key;
  logic [31:0] address;
  logic [32:0] expiry;
  logic [31:0] last_use;

  tlc_token_t tok_next;

  logic hit_me;
  assign hit_me = wcmd.en && (wcmd.idx == SLOT_IDX);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.match && valid && (key == tok_in.name_key)) begin
      tok_next.match      = 1'b1;
      tok_next.match_idx  = SLOT_IDX;
      tok_next.match_addr = address;
      tok_next.match_exp  = expiry;
    end
    if (!tok_in.free_hit && !valid) begin
      tok_next.free_hit = 1'b1;
      tok_next.free_idx = SLOT_IDX;
    end
    // Strict compare keeps the lowest index on a tie.
    if (last_use < tok_in.oldest) begin
      tok_next.oldest     = last_use;
      tok_next.oldest_idx = SLOT_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      last_use <= '0;
    end else if (wcmd.en && wcmd.kind == WR_CLEAR) begin
      valid <= 1'b0;
    end else if (hit_me) begin
      unique case (wcmd.kind)
        WR_FULL: begin
          valid    <= 1'b1;
          last_use <= wcmd.now;
        end
        WR_TOUCH: last_use <= wcmd.now;
        WR_KILL:  valid    <= 1'b0;
        default:  valid    <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit_me && wcmd.kind == WR_FULL) begin
      key     <= wcmd.name_key;
      address <= wcmd.address;
      expiry  <= wcmd.expiry;
    end
  end

endmodule

[hdl/tlc_ctrl.sv]
// ----------------------------------------------------------------------------
// tlc_ctrl: request sequencer of the cache
// Takes an item, launches a scan token down the row of cells, decides the
// outcome from the returned token and broadcasts the write-back, if any.
// ----------------------------------------------------------------------------
module tlc_ctrl
  import tlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tlc_req_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tlc_rsp_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output tlc_token_t  tok_head,
  input  tlc_token_t  tok_tail,
  output tlc_wcmd_t   wcmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t      state;
  logic [31:0] max_ttl;

  logic [1:0]  req_op;
  logic [63:0] req_key;
  logic [31:0] req_addr;
  logic [31:0] req_ttl;
  logic        req_bad;
  logic [31:0] req_now;
  tlc_token_t  res_tok;

  logic      out_free;
  tlc_rsp_t  rsp_next;
  tlc_wcmd_t wcmd_next;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    rsp_next          = '0;
    rsp_next.status   = ST_MISS;
    wcmd_next         = '0;
    wcmd_next.kind    = WR_FULL;
    wcmd_next.name_key = req_key;
    wcmd_next.address = req_addr;
    wcmd_next.expiry  = {1'b0, req_now} + {1'b0, req_ttl};
    wcmd_next.now     = req_now;
    unique case (req_op)
      OP_LOOKUP: begin
        if (res_tok.match) begin
          wcmd_next.en  = 1'b1;
          wcmd_next.idx = res_tok.match_idx;
          if ({1'b0, req_now} >= res_tok.match_exp) begin
            rsp_next.status = ST_EXPIRED;
            wcmd_next.kind  = WR_KILL;
          end else begin
            rsp_next.status      = ST_HIT;
            rsp_next.hit         = 1'b1;
            rsp_next.address_out = res_tok.match_addr;
            wcmd_next.kind       = WR_TOUCH;
          end
        end
      end
      OP_INSERT: begin
        if (req_bad) begin
          rsp_next.status = ST_REJECTED;
        end else begin
          wcmd_next.en = 1'b1;
          priority if (res_tok.match) begin
            rsp_next.status = ST_UPDATED;
            wcmd_next.idx   = res_tok.match_idx;
          end else if (res_tok.free_hit) begin
            rsp_next.status = ST_FILLED;
            wcmd_next.idx   = res_tok.free_idx;
          end else begin
            rsp_next.status = ST_EVICTED;
            wcmd_next.idx   = res_tok.oldest_idx;
          end
        end
      end
      OP_CLEAR: begin
        rsp_next.status = ST_CLEARED;
        wcmd_next.en    = 1'b1;
        wcmd_next.kind  = WR_CLEAR;
      end
      default: rsp_next.status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ttl <= MAX_TTL_RESET;
    end else if (cfg_wr_en) begin
      max_ttl <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      tok_head  <= '0;
      wcmd      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // The write-back issued on leaving the decision step lasts one cycle.
          wcmd.en <= 1'b0;
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_valid) begin
            req_op   <= in_data.opcode;
            req_key  <= in_data.name_key;
            req_addr <= in_data.address_in;
            req_ttl  <= (in_data.ttl_in > max_ttl) ? max_ttl : in_data.ttl_in;
            req_bad  <= (in_data.address_in == '0) || (in_data.address_in == ALL_ONES32)
                        || (in_data.ttl_in == '0);
            req_now  <= in_data.now_seconds;
            tok_head <= '{active: 1'b1, name_key: in_data.name_key, match: 1'b0,
                          match_idx: '0, match_addr: '0, match_exp: '0,
                          free_hit: 1'b0, free_idx: '0, oldest: ALL_ONES32,
                          oldest_idx: '0};
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          tok_head.active <= 1'b0;
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (tok_tail.active) begin
            res_tok <= tok_tail;
            state   <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            out_data  <= rsp_next;
            out_valid <= 1'b1;
            wcmd      <= wcmd_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ttl_lru_lookup_cache_core.sv]
// ----------------------------------------------------------------------------
// ttl_lru_lookup_cache_core: fully associative cache with TTL expiry and LRU
// Key to address cache built as a row of slot cells scanned by a token.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (lookup, insert or clear)
//   and each item yields exactly one result on out_valid/out_ready/out_data.
//   max_ttl is written through cfg_wr_en/cfg_wr_data; the user must write it
//   only while the block is idle, as the block itself does not enforce this.
//   An accepted item sends a scan token through the ENTRIES slot cells, one
//   cell per cycle, which gathers the first match, the first free slot and
//   the least recently used slot. The controller then decides the outcome
//   and broadcasts at most one write-back to the cells. The token is
//   registered in each cell in turn, taken in the scan step and decided
//   in the apply step; no new item is accepted until that step is left.
//   The result sits in an output register: a new item is accepted while it
//   waits, but if the receiver stalls the next item holds in its decision
//   step until the register frees.
//   Synchronous reset empties every slot, zeroes the recency times and sets
//   max_ttl to 86400.
// ----------------------------------------------------------------------------
module ttl_lru_lookup_cache_core
  import tlc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tlc_req_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output tlc_rsp_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  tlc_token_t chain [ENTRIES+1];
  tlc_wcmd_t  wcmd;

  tlc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_head    (chain[0]),
    .tok_tail    (chain[ENTRIES]),
    .wcmd        (wcmd)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tlc_cell #(
      .SLOT (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .wcmd    (wcmd),
      .tok_out (chain[g+1])
    );
  end

endmodule
